// File: rtl/core/gds_pkg.sv
`timescale 1ns / 1ps
package gds_pkg;

  localparam int OUT_WIDTH = 48;
  localparam int NUM_CFG   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W    = 6;
  localparam int STEP_W    = 16;
  localparam int COEF_W    = 7;
  localparam int TAP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } gds_state_t;

  typedef struct packed {
    logic load;
    logic write_en;
    logic rd_issue;
    logic rd_capture;
    logic scale;
    logic sum;
    logic div_start;
    logic finish;
  } gds_cmd_t;

  typedef struct packed {
    logic is_query;
    logic outside;
    logic tap_last;
    logic div_done;
  } gds_sts_t;

  // Coefficient for a stencil row and tap. Rows 0..4 are the five-point
  // rows; rows 5..7 are the three-point rows (low edge, central, high edge).
  function automatic logic signed [COEF_W-1:0] coef(input logic [2:0] row,
                                                    input logic [TAP_W-1:0] tap);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case ({row, tap})
      {3'd0, 3'd0}: c = -7'sd25;
      {3'd0, 3'd1}: c = 7'sd48;
      {3'd0, 3'd2}: c = -7'sd36;
      {3'd0, 3'd3}: c = 7'sd16;
      {3'd0, 3'd4}: c = -7'sd3;
      {3'd1, 3'd0}: c = -7'sd3;
      {3'd1, 3'd1}: c = -7'sd10;
      {3'd1, 3'd2}: c = 7'sd18;
      {3'd1, 3'd3}: c = -7'sd6;
      {3'd1, 3'd4}: c = 7'sd1;
      {3'd2, 3'd0}: c = 7'sd1;
      {3'd2, 3'd1}: c = -7'sd8;
      {3'd2, 3'd3}: c = 7'sd8;
      {3'd2, 3'd4}: c = -7'sd1;
      {3'd3, 3'd0}: c = -7'sd1;
      {3'd3, 3'd1}: c = 7'sd6;
      {3'd3, 3'd2}: c = -7'sd18;
      {3'd3, 3'd3}: c = 7'sd10;
      {3'd3, 3'd4}: c = 7'sd3;
      {3'd4, 3'd0}: c = 7'sd3;
      {3'd4, 3'd1}: c = -7'sd16;
      {3'd4, 3'd2}: c = 7'sd36;
      {3'd4, 3'd3}: c = -7'sd48;
      {3'd4, 3'd4}: c = 7'sd25;
      {3'd5, 3'd0}: c = -7'sd3;
      {3'd5, 3'd1}: c = 7'sd4;
      {3'd5, 3'd2}: c = -7'sd1;
      {3'd6, 3'd0}: c = -7'sd1;
      {3'd6, 3'd2}: c = 7'sd1;
      {3'd7, 3'd0}: c = 7'sd1;
      {3'd7, 3'd1}: c = -7'sd4;
      {3'd7, 3'd2}: c = 7'sd3;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/grid_divergence_stencil.sv
`timescale 1ns / 1ps
// Divergence stencil over a stored 3-D vector field.
// Input channel in_valid/in_stall carries one word: operation 0 stores
// comp_x/y/z at (pos_x, pos_y, pos_z); operation 1 queries the divergence.
// Each word gives exactly one result word on out_valid/out_stall.
// Configuration: write cfg_wr_en with cfg_index/cfg_data, only while idle.
// One word is in flight at a time: the next word is taken only after the
// result of the last one has left. A write or an out-of-grid query goes
// from the read state straight to the result. A query issues one tap
// address per cycle on the single-port component memories, then scales,
// sums and divides; the divide is one step for the halving and four
// chunk steps for the divide by 12.
// Reset clears the controller and loads default registers; memory
// contents stay undefined until written. While out_stall is high the
// result holds and in_stall stays high.
module grid_divergence_stencil
  import gds_pkg::*;
#(
  parameter int AXIS_BITS  = 5,
  parameter int COMP_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [AXIS_BITS-1:0]         in_pos_x,
  input  logic [AXIS_BITS-1:0]         in_pos_y,
  input  logic [AXIS_BITS-1:0]         in_pos_z,
  input  logic signed [COMP_WIDTH-1:0] in_comp_x,
  input  logic signed [COMP_WIDTH-1:0] in_comp_y,
  input  logic signed [COMP_WIDTH-1:0] in_comp_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_WIDTH-1:0]  out_divergence,
  output logic                         out_out_of_grid,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  logic              scheme_r;
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [STEP_W-1:0] step_x_r, step_y_r, step_z_r;
  gds_cmd_t cmd;
  gds_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r <= 1'b0;
      size_x_r <= SIZE_W'(32); size_y_r <= SIZE_W'(32); size_z_r <= SIZE_W'(32);
      step_x_r <= STEP_W'(256); step_y_r <= STEP_W'(256); step_z_r <= STEP_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCHEME: scheme_r <= cfg_data[0];
        CFG_SIZE_X: size_x_r <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y: size_y_r <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z: size_z_r <= cfg_data[SIZE_W-1:0];
        CFG_STEP_X: step_x_r <= cfg_data;
        CFG_STEP_Y: step_y_r <= cfg_data;
        CFG_STEP_Z: step_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gds_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  gds_dp #(.AXIS_BITS(AXIS_BITS), .COMP_WIDTH(COMP_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z), .in_comp_x(in_comp_x), .in_comp_y(in_comp_y),
    .in_comp_z(in_comp_z), .scheme_r(scheme_r), .size_x_r(size_x_r),
    .size_y_r(size_y_r), .size_z_r(size_z_r), .step_x_r(step_x_r),
    .step_y_r(step_y_r), .step_z_r(step_z_r), .out_divergence(out_divergence),
    .out_out_of_grid(out_out_of_grid));

endmodule

// File: rtl/core/gds_ram.sv
`timescale 1ns / 1ps
module gds_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/gds_ctrl.sv
`timescale 1ns / 1ps
module gds_ctrl
  import gds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  gds_sts_t sts,
  output gds_cmd_t cmd
);

  gds_state_t state_r, state_nxt;
  logic       rd_pend_r, rd_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rd_pend_nxt = 1'b0;
    cmd         = '0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // one tap address per cycle, data lands in the next cycle
        cmd.rd_capture = rd_pend_r;
        if (!sts.is_query) begin
          cmd.write_en = 1'b1;
          state_nxt    = ST_OUT;
          cmd.finish   = 1'b1;
        end else if (sts.outside) begin
          state_nxt  = ST_OUT;
          cmd.finish = 1'b1;
        end else if (rd_pend_r && !cmd.rd_issue && sts.tap_last) begin
          state_nxt = ST_SCALE;
        end else begin
          cmd.rd_issue = 1'b1;
          rd_pend_nxt  = 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/gds_dp.sv
`timescale 1ns / 1ps
module gds_dp
  import gds_pkg::*;
#(
  parameter int AXIS_BITS  = 5,
  parameter int COMP_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gds_cmd_t                     cmd,
  output gds_sts_t                     sts,
  input  logic                         in_operation,
  input  logic [AXIS_BITS-1:0]         in_pos_x,
  input  logic [AXIS_BITS-1:0]         in_pos_y,
  input  logic [AXIS_BITS-1:0]         in_pos_z,
  input  logic signed [COMP_WIDTH-1:0] in_comp_x,
  input  logic signed [COMP_WIDTH-1:0] in_comp_y,
  input  logic signed [COMP_WIDTH-1:0] in_comp_z,
  input  logic                         scheme_r,
  input  logic [SIZE_W-1:0]            size_x_r,
  input  logic [SIZE_W-1:0]            size_y_r,
  input  logic [SIZE_W-1:0]            size_z_r,
  input  logic [STEP_W-1:0]            step_x_r,
  input  logic [STEP_W-1:0]            step_y_r,
  input  logic [STEP_W-1:0]            step_z_r,
  output logic signed [OUT_WIDTH-1:0]  out_divergence,
  output logic                         out_out_of_grid
);

  localparam int ADDR_W = 3 * AXIS_BITS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int NW     = AXIS_BITS + 1;
  localparam logic [NW-1:0] AXIS_LEN = NW'(1 << AXIS_BITS);
  localparam int ACC_W  = COMP_WIDTH + 9;
  localparam int PROD_W = ACC_W + STEP_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic                 op_r;
  logic [AXIS_BITS-1:0] px_r, py_r, pz_r;
  logic signed [COMP_WIDTH-1:0] cx_r, cy_r, cz_r;
  logic                 outside_r;
  logic [NW-1:0]        nx_r, ny_r, nz_r;
  logic [TAP_W-1:0]     tap_r, cap_tap_r;
  logic signed [ACC_W-1:0] accx_r, accy_r, accz_r;
  logic signed [PROD_W-1:0] prx_r, pry_r, prz_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [OUT_WIDTH-1:0] div_r;
  logic                 oog_r;

  function automatic logic [NW-1:0] eff(input logic [SIZE_W-1:0] s);
    logic [NW-1:0] r;
    if (s < SIZE_W'(5)) r = NW'(5);
    else if (int'(s) > (1 << AXIS_BITS)) r = AXIS_LEN;
    else r = NW'(s);
    return r;
  endfunction

  // row select and window start for one axis
  function automatic logic [2:0] row_of(input logic [AXIS_BITS-1:0] k,
                                        input logic [NW-1:0] n, input logic five);
    logic [NW-1:0] kk;
    logic [2:0] r;
    kk = NW'(k);
    if (five) begin
      if (kk == '0) r = 3'd0;
      else if (kk == NW'(1)) r = 3'd1;
      else if (kk == n - NW'(2)) r = 3'd3;
      else if (kk == n - NW'(1)) r = 3'd4;
      else r = 3'd2;
    end else begin
      if (kk == '0) r = 3'd5;
      else if (kk == n - NW'(1)) r = 3'd7;
      else r = 3'd6;
    end
    return r;
  endfunction

  function automatic logic [AXIS_BITS-1:0] start_of(input logic [AXIS_BITS-1:0] k,
                                                    input logic [NW-1:0] n,
                                                    input logic [2:0] r);
    logic [NW-1:0] s;
    case (r)
      3'd0, 3'd1, 3'd5: s = '0;
      3'd3, 3'd4: s = n - NW'(5);
      3'd7: s = n - NW'(3);
      3'd2: s = NW'(k) - NW'(2);
      default: s = NW'(k) - NW'(1);
    endcase
    return s[AXIS_BITS-1:0];
  endfunction

  logic [2:0] rowx, rowy, rowz;
  logic [AXIS_BITS-1:0] stx, sty, stz;
  logic [AXIS_BITS-1:0] tx, ty, tz;
  logic [ADDR_W-1:0] ax, ay, az, wa;
  logic we;
  logic [COMP_WIDTH-1:0] rx, ry, rz;
  logic [TAP_W-1:0] ntaps;

  always_comb begin
    rowx = row_of(px_r, nx_r, scheme_r);
    rowy = row_of(py_r, ny_r, scheme_r);
    rowz = row_of(pz_r, nz_r, scheme_r);
    stx  = start_of(px_r, nx_r, rowx);
    sty  = start_of(py_r, ny_r, rowy);
    stz  = start_of(pz_r, nz_r, rowz);
    tx   = stx + AXIS_BITS'(tap_r);
    ty   = sty + AXIS_BITS'(tap_r);
    tz   = stz + AXIS_BITS'(tap_r);
    wa   = {pz_r, py_r, px_r};
    we   = cmd.write_en;
    ax   = we ? wa : {pz_r, py_r, tx};
    ay   = we ? wa : {pz_r, ty, px_r};
    az   = we ? wa : {tz, py_r, px_r};
    ntaps = scheme_r ? TAP_W'(5) : TAP_W'(3);
  end

  gds_ram #(.WIDTH(COMP_WIDTH), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(we), .addr(ax), .wdata(cx_r), .rdata(rx));
  gds_ram #(.WIDTH(COMP_WIDTH), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(we), .addr(ay), .wdata(cy_r), .rdata(ry));
  gds_ram #(.WIDTH(COMP_WIDTH), .DEPTH(DEPTH)) u_ram_z (
    .clk(clk), .we(we), .addr(az), .wdata(cz_r), .rdata(rz));

  // divide unit: scheme 0 halves; scheme 1 divides the magnitude by 12 one
  // 13-bit chunk per cycle, most significant first. Each chunk step takes
  // floor(x / 12) as floor((x >> 2) / 3) by a reciprocal multiply, exact
  // because x >> 2 stays below 2^17.
  localparam int CH_W     = 13;
  localparam int NCH      = (SUM_W + CH_W - 1) / CH_W;
  localparam int MAG_W    = NCH * CH_W;
  localparam int CNT_W    = $clog2(NCH + 1);
  localparam int DVD_W    = CH_W + 4;
  localparam int RECIP_SH = 17;
  localparam logic [15:0] RECIP3 = 16'd43691;

  logic [MAG_W-1:0] mag_r, quo_r;
  logic [3:0]       rem_r;
  logic             neg_r, div_busy_r, div_done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd;
  logic [30:0]      dprod;
  logic [CH_W-1:0]  qdig;
  logic [3:0]       rdig;
  logic [SUM_W-1:0] abs_sum;
  logic signed [SUM_W-1:0] half;
  logic signed [MAG_W-1:0] qs;

  always_comb begin
    abs_sum = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    dvd     = {rem_r, mag_r[MAG_W-1 -: CH_W]};
    dprod   = 31'(dvd[DVD_W-1:2]) * 31'(RECIP3);
    qdig    = dprod[RECIP_SH +: CH_W];
    rdig    = 4'(dvd - DVD_W'(qdig) * DVD_W'(12));
    half    = (sum_r + $signed({{(SUM_W-1){1'b0}}, sum_r[SUM_W-1]})) >>> 1;
    qs      = neg_r ? -$signed(quo_r) : $signed(quo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r      <= '0;
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.load) tap_r <= '0;
      else if (cmd.rd_issue) tap_r <= tap_r + TAP_W'(1);
      if (cmd.div_start && !div_busy_r && !div_done_r) begin
        if (!scheme_r) begin
          div_done_r <= 1'b1;
        end else begin
          div_busy_r <= 1'b1;
        end
      end else if (div_busy_r && cnt_r == '0) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
      cx_r <= in_comp_x; cy_r <= in_comp_y; cz_r <= in_comp_z;
      nx_r <= eff(size_x_r); ny_r <= eff(size_y_r); nz_r <= eff(size_z_r);
      outside_r <= (NW'(in_pos_x) >= eff(size_x_r)) || (NW'(in_pos_y) >= eff(size_y_r))
                   || (NW'(in_pos_z) >= eff(size_z_r));
      accx_r <= '0; accy_r <= '0; accz_r <= '0;
    end
    cap_tap_r <= tap_r;
    if (cmd.rd_capture) begin
      accx_r <= accx_r + ACC_W'($signed(rx)) * ACC_W'(coef(rowx, cap_tap_r));
      accy_r <= accy_r + ACC_W'($signed(ry)) * ACC_W'(coef(rowy, cap_tap_r));
      accz_r <= accz_r + ACC_W'($signed(rz)) * ACC_W'(coef(rowz, cap_tap_r));
    end
    if (cmd.scale) begin
      prx_r <= PROD_W'(accx_r) * $signed({1'b0, step_x_r});
      pry_r <= PROD_W'(accy_r) * $signed({1'b0, step_y_r});
      prz_r <= PROD_W'(accz_r) * $signed({1'b0, step_z_r});
    end
    if (cmd.sum) sum_r <= SUM_W'(prx_r) + SUM_W'(pry_r) + SUM_W'(prz_r);
    if (cmd.div_start && !div_busy_r && !div_done_r) begin
      mag_r <= MAG_W'(abs_sum);
      neg_r <= sum_r[SUM_W-1];
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= CNT_W'(NCH - 1);
    end else if (div_busy_r) begin
      mag_r <= mag_r << CH_W;
      rem_r <= rdig;
      quo_r <= {quo_r[MAG_W-CH_W-1:0], qdig};
      if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.finish) begin
      oog_r <= outside_r;
      if (op_r == OP_WRITE || outside_r) div_r <= '0;
      else if (scheme_r) div_r <= OUT_WIDTH'(qs);
      else div_r <= OUT_WIDTH'(half);
    end
  end

  assign sts.is_query = (op_r == OP_QUERY);
  assign sts.outside  = outside_r;
  assign sts.tap_last = (cap_tap_r == ntaps - TAP_W'(1));
  assign sts.div_done = div_done_r;
  assign out_divergence  = div_r;
  assign out_out_of_grid = oog_r;

endmodule

// File: verif/tb_grid_divergence_stencil.sv
`timescale 1ns / 1ps
module tb_grid_divergence_stencil
  import gds_pkg::*;
();

  localparam int AXB   = 5;
  localparam int CW    = 24;
  localparam int DEPTH = 1 << (3 * AXB);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] div;
    logic                 oog;
  } result_t;

  typedef struct {
    logic                 op;
    logic [AXB-1:0]       px, py, pz;
    logic [CW-1:0]        cx, cy, cz;
    bit                   typed;
    logic [OUT_WIDTH-1:0] div;
    logic                 oog;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic [AXB-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [CW-1:0] in_comp_x, in_comp_y, in_comp_z;
  logic out_valid, out_stall;
  logic signed [OUT_WIDTH-1:0] out_divergence;
  logic out_out_of_grid;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_divergence_stencil i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_divergence(out_divergence), .out_out_of_grid(out_out_of_grid),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block's field memories and registers
  logic signed [CW-1:0] fld_x [DEPTH];
  logic signed [CW-1:0] fld_y [DEPTH];
  logic signed [CW-1:0] fld_z [DEPTH];
  bit                   written [DEPTH];
  bit          five_pt;
  int unsigned reg_size [3];
  int unsigned reg_step [3];

  int co5 [5][5] = '{'{-25, 48, -36, 16, -3}, '{-3, -10, 18, -6, 1},
                     '{1, -8, 0, 8, -1}, '{-1, 6, -18, 10, 3},
                     '{3, -16, 36, -48, 25}};
  int co3 [3][3] = '{'{-3, 4, -1}, '{-1, 0, 1}, '{1, -4, 3}};

  result_t div_expect_q [$];
  int err_cnt, n_writes, n_queries, n_oog, burst_left;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timeout at %0t with %0d results outstanding", $time, div_expect_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned eff_size(int unsigned s);
    if (s < 5) return 5;
    if (s > 32) return 32;
    return s;
  endfunction

  function automatic int unsigned vox_addr(int unsigned x, int unsigned y, int unsigned z);
    return (z << (2 * AXB)) | (y << AXB) | x;
  endfunction

  // weighted stencil sum along one axis (0 x, 1 y, 2 z)
  function automatic longint axis_sum(int axis, int unsigned p [3]);
    int unsigned n, k, start, row, taps, a;
    int unsigned q [3];
    longint acc, v;
    n = eff_size(reg_size[axis]);
    k = p[axis];
    acc = 0;
    if (five_pt) begin
      taps = 5;
      if (k == 0) begin row = 0; start = 0; end
      else if (k == 1) begin row = 1; start = 0; end
      else if (k == n - 2) begin row = 3; start = n - 5; end
      else if (k == n - 1) begin row = 4; start = n - 5; end
      else begin row = 2; start = k - 2; end
    end else begin
      taps = 3;
      if (k == 0) begin row = 0; start = 0; end
      else if (k == n - 1) begin row = 2; start = n - 3; end
      else begin row = 1; start = k - 1; end
    end
    for (int i = 0; i < taps; i++) begin
      q = p;
      q[axis] = start + i;
      a = vox_addr(q[0], q[1], q[2]);
      v = (axis == 0) ? longint'(fld_x[a]) : (axis == 1) ? longint'(fld_y[a])
                                                        : longint'(fld_z[a]);
      acc += longint'(five_pt ? co5[row][i] : co3[row][i]) * v;
    end
    return acc;
  endfunction

  // apply one accepted word to the shadow state and return its result
  function automatic result_t predict_divergence(logic op, int unsigned px,
      int unsigned py, int unsigned pz, logic [CW-1:0] cx, logic [CW-1:0] cy,
      logic [CW-1:0] cz);
    result_t r;
    int unsigned p [3];
    int unsigned a;
    longint total;
    p = '{px, py, pz};
    a = vox_addr(px, py, pz);
    r.oog = (px >= eff_size(reg_size[0])) || (py >= eff_size(reg_size[1])) ||
            (pz >= eff_size(reg_size[2]));
    r.div = '0;
    if (op == OP_WRITE) begin
      fld_x[a] = cx;
      fld_y[a] = cy;
      fld_z[a] = cz;
      written[a] = 1'b1;
    end else if (!r.oog) begin
      total = 0;
      for (int ax = 0; ax < 3; ax++)
        total += axis_sum(ax, p) * longint'(reg_step[ax]);
      total = five_pt ? total / 12 : total / 2;
      r.div = total[OUT_WIDTH-1:0];
    end
    return r;
  endfunction

  // drive one word at a falling edge, hold it until accepted
  task automatic send_word(logic op, int unsigned px, int unsigned py, int unsigned pz,
      logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
      bit typed = 0, logic [OUT_WIDTH-1:0] tdiv = '0, logic toog = 1'b0);
    result_t r;
    int gap;
    in_valid     = 1'b1;
    in_operation = op;
    in_pos_x     = px[AXB-1:0];
    in_pos_y     = py[AXB-1:0];
    in_pos_z     = pz[AXB-1:0];
    in_comp_x    = cx;
    in_comp_y    = cy;
    in_comp_z    = cz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_divergence(op, px[AXB-1:0], py[AXB-1:0], pz[AXB-1:0], cx, cy, cz);
    if (typed) begin
      r.div = tdiv;
      r.oog = toog;
    end
    div_expect_q.push_back(r);
    if (op == OP_WRITE) n_writes++;
    else n_queries++;
    @(negedge clk);
    in_valid = 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(0, 5);
      repeat (gap) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_SCHEME: five_pt = data[0];
      CFG_SIZE_X: reg_size[0] = data[SIZE_W-1:0];
      CFG_SIZE_Y: reg_size[1] = data[SIZE_W-1:0];
      CFG_SIZE_Z: reg_size[2] = data[SIZE_W-1:0];
      CFG_STEP_X: reg_step[0] = data;
      CFG_STEP_Y: reg_step[1] = data;
      CFG_STEP_Z: reg_step[2] = data;
      default: ;
    endcase
  endtask

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      default: return CW'($urandom());
    endcase
  endfunction

  // bias coordinates toward the stencil edges
  function automatic int unsigned rand_coord(int unsigned n);
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, 1);
      2, 3: return n - 1 - $urandom_range(0, 1);
      4, 5, 6, 7: return $urandom_range(0, n - 1);
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  task automatic drain();
    while (div_expect_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // store every grid voxel not yet written so any in-grid query is legal
  task automatic fill_grid();
    for (int z = 0; z < eff_size(reg_size[2]); z++)
      for (int y = 0; y < eff_size(reg_size[1]); y++)
        for (int x = 0; x < eff_size(reg_size[0]); x++)
          if (!written[vox_addr(x, y, z)])
            send_word(OP_WRITE, x, y, z, rand_comp(), rand_comp(), rand_comp());
  endtask

  // receiver: stall pattern changes at random, plus one long hold
  initial begin
    int mode, hold_cnt;
    out_stall = 1'b0;
    mode = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall = 1'b1;
      end else begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) < 3);
          default: out_stall = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (div_expect_q.size() == 0) begin
        $display("%0t: unexpected word div=%h oog=%b", $time, out_divergence,
                 out_out_of_grid);
        err_cnt++;
      end else begin
        want = div_expect_q.pop_front();
        if (out_out_of_grid) n_oog++;
        if (out_divergence !== want.div) begin
          $display("%0t: divergence expected %h actual %h", $time, want.div,
                   out_divergence);
          err_cnt++;
        end
        if (out_out_of_grid !== want.oog) begin
          $display("%0t: out_of_grid expected %b actual %b", $time, want.oog,
                   out_out_of_grid);
          err_cnt++;
        end
      end
    end
  end

  dir_row_t reset_rows [3] = '{
    '{OP_WRITE, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, '0, 1'b0},
    '{OP_WRITE, 31, 31, 31, 24'h800000, 24'h800000, 24'h800000, 1, '0, 1'b0},
    '{OP_WRITE, 31, 0, 17, 24'hAAAAAA, 24'h555555, 24'hFFFFFF, 1, '0, 1'b0}
  };

  dir_row_t grid_rows [10] = '{
    '{OP_QUERY, 0, 0, 0, '0, '0, '0, 0, '0, 1'b0},
    '{OP_QUERY, 4, 4, 4, '0, '0, '0, 0, '0, 1'b0},
    '{OP_QUERY, 1, 2, 3, '0, '0, '0, 0, '0, 1'b0},
    '{OP_QUERY, 4, 0, 2, '0, '0, '0, 0, '0, 1'b0},
    '{OP_QUERY, 5, 0, 0, '0, '0, '0, 1, '0, 1'b1},
    '{OP_QUERY, 0, 5, 0, '0, '0, '0, 1, '0, 1'b1},
    '{OP_QUERY, 0, 0, 5, '0, '0, '0, 1, '0, 1'b1},
    '{OP_QUERY, 31, 31, 31, '0, '0, '0, 1, '0, 1'b1},
    '{OP_WRITE, 31, 31, 31, 24'h123456, 24'hFEDCBA, 24'h000001, 1, '0, 1'b1},
    '{OP_WRITE, 2, 2, 2, 24'h800000, 24'h7FFFFF, 24'h000000, 0, '0, 1'b0}
  };

  // scheme, size x/y/z, step x/y/z per phase; a zero step is drawn at random
  int unsigned phase_cfg [NUM_PHASES][7] = '{
    '{0, 5, 5, 5, 256, 256, 256},
    '{1, 5, 5, 5, 1, 65535, 256},
    '{0, 12, 5, 5, 65535, 65535, 65535},
    '{1, 5, 32, 5, 0, 0, 0},
    '{1, 16'hFFC0, 63, 16'h0003, 0, 0, 0},
    '{1, 7, 6, 8, 0, 0, 0}
  };

  initial begin
    int unsigned v, nx, ny, nz;
    dir_row_t d;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_WRITE;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_comp_x = '0; in_comp_y = '0; in_comp_z = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SCHEME;
    cfg_data = '0;
    err_cnt = 0; n_writes = 0; n_queries = 0; n_oog = 0; burst_left = 0;
    hold_req = 1'b0;
    five_pt = 1'b0;
    reg_size = '{32, 32, 32};
    reg_step = '{256, 256, 256};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (reset_rows[i]) begin
      d = reset_rows[i];
      send_word(d.op, d.px, d.py, d.pz, d.cx, d.cy, d.cz, d.typed, d.div, d.oog);
    end
    drain();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_reg(CFG_SCHEME, CFG_DATA_W'(phase_cfg[ph][0]));
      write_reg(CFG_SIZE_X, CFG_DATA_W'(phase_cfg[ph][1]));
      write_reg(CFG_SIZE_Y, CFG_DATA_W'(phase_cfg[ph][2]));
      write_reg(CFG_SIZE_Z, CFG_DATA_W'(phase_cfg[ph][3]));
      write_reg(CFG_STEP_X, CFG_DATA_W'(phase_cfg[ph][4] != 0 ? phase_cfg[ph][4]
                                                                : $urandom()));
      write_reg(CFG_STEP_Y, CFG_DATA_W'(phase_cfg[ph][5] != 0 ? phase_cfg[ph][5]
                                                                : $urandom()));
      write_reg(CFG_STEP_Z, CFG_DATA_W'(phase_cfg[ph][6] != 0 ? phase_cfg[ph][6]
                                                                : $urandom()));
      fill_grid();
      if (ph == 0) begin
        foreach (grid_rows[i]) begin
          d = grid_rows[i];
          send_word(d.op, d.px, d.py, d.pz, d.cx, d.cy, d.cz, d.typed, d.div, d.oog);
        end
      end
      // hold the result side while input keeps coming, so the block backs up
      if (ph == 2) hold_req = 1'b1;
      nx = eff_size(reg_size[0]);
      ny = eff_size(reg_size[1]);
      nz = eff_size(reg_size[2]);
      repeat (150) begin
        v = $urandom_range(0, 9);
        if (v < 4)
          send_word(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), rand_comp(), rand_comp(), rand_comp());
        else
          send_word(OP_QUERY, rand_coord(nx), rand_coord(ny), rand_coord(nz),
                    CW'($urandom()), CW'($urandom()), CW'($urandom()));
      end
    end

    drain();
    repeat (100) @(negedge clk);
    $display("Covered %0d voxel writes and %0d queries over %0d register settings,",
             n_writes, n_queries, NUM_PHASES);
    $display("both stencil schemes, %0d out-of-grid results.", n_oog);
    if (err_cnt == 0 && div_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, div_expect_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
